// ===== hdl/tdsm_pkg.sv =====
// Shared types, constants and the sequencer's microcode table for the switch matcher.
`timescale 1ns / 1ps

package tdsm_pkg;

  localparam int unsigned SLOTS_DEFAULT = 16;
  localparam int unsigned OPCODE_W      = 2;
  localparam int unsigned SLOT_W        = 4;
  localparam int unsigned MINUTE_W      = 11;
  localparam int unsigned CMD_W         = 6;
  // Working width of the time-of-day sum: boot time plus elapsed minutes.
  localparam int unsigned SUM_W         = MINUTE_W + 1;

  localparam logic [SUM_W-1:0] DAY_MINUTES = SUM_W'(24 * 60);

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD_ON  = 2'd0,
    OP_LOAD_OFF = 2'd1,
    OP_COMPARE  = 2'd2,
    OP_NONE     = 2'd3
  } opcode_e;

  // Microcode addresses.
  typedef enum logic [2:0] {
    STEP_IDLE,
    STEP_ADD,
    STEP_WRAP,
    STEP_ON,
    STEP_ON_END,
    STEP_OFF,
    STEP_OUT
  } step_e;

  // Datapath operation selected by a control word.
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_CAPTURE,
    ACT_ADD,
    ACT_WRAP,
    ACT_SCAN_ON,
    ACT_SCAN_OFF,
    ACT_EMIT
  } act_e;

  // Jump condition of a control word.
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_NO_COMPARE,
    COND_WRAP,
    COND_ON_MORE,
    COND_OFF_MORE,
    COND_HIT,
    COND_OUT_BUSY
  } cond_e;

  typedef struct packed {
    logic  ready;
    act_e  act;
    cond_e cond;
    step_e target_step;
    step_e next_step;
  } ctrl_t;

  // The program: when the condition holds the sequencer jumps to target_step,
  // otherwise it moves on to next_step.
  function automatic ctrl_t tdsm_ucode(step_e step);
    ctrl_t cw;
    cw = '{ready: 1'b0, act: ACT_NONE, cond: COND_NEVER,
           target_step: STEP_IDLE, next_step: STEP_IDLE};
    unique case (step)
      STEP_IDLE: begin
        cw = '{ready: 1'b1, act: ACT_CAPTURE, cond: COND_NO_COMPARE,
               target_step: STEP_IDLE, next_step: STEP_ADD};
      end
      STEP_ADD: begin
        cw = '{ready: 1'b0, act: ACT_ADD, cond: COND_NEVER,
               target_step: STEP_IDLE, next_step: STEP_WRAP};
      end
      STEP_WRAP: begin
        cw = '{ready: 1'b0, act: ACT_WRAP, cond: COND_WRAP,
               target_step: STEP_WRAP, next_step: STEP_ON};
      end
      STEP_ON: begin
        cw = '{ready: 1'b0, act: ACT_SCAN_ON, cond: COND_ON_MORE,
               target_step: STEP_ON, next_step: STEP_ON_END};
      end
      STEP_ON_END: begin
        cw = '{ready: 1'b0, act: ACT_NONE, cond: COND_HIT,
               target_step: STEP_OUT, next_step: STEP_OFF};
      end
      STEP_OFF: begin
        cw = '{ready: 1'b0, act: ACT_SCAN_OFF, cond: COND_OFF_MORE,
               target_step: STEP_OFF, next_step: STEP_OUT};
      end
      STEP_OUT: begin
        cw = '{ready: 1'b0, act: ACT_EMIT, cond: COND_OUT_BUSY,
               target_step: STEP_OUT, next_step: STEP_IDLE};
      end
      default: begin
        cw = '{ready: 1'b0, act: ACT_NONE, cond: COND_NEVER,
               target_step: STEP_IDLE, next_step: STEP_IDLE};
      end
    endcase
    return cw;
  endfunction

endpackage

// ===== hdl/tdsm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module tdsm_ram #(
  parameter int unsigned Width = 11,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/time_of_day_switch_matcher.sv =====
// Top level of the time-of-day switch matcher: microcoded scan over on and off tables.
`timescale 1ns / 1ps

// Usage: the input channel (in_valid_i / in_stall_o) carries one transaction per
// item. Opcode load-on or load-off writes one slot of the on-time or off-time table
// and its valid mark; it gives no result. Opcode compare carries the minutes since
// boot; the block adds the boot time, wraps the sum to a minute of day and returns
// one result transaction on the output channel (out_valid_o / out_stall_i) with the
// switch command and the minute it compared. The configuration channel writes the
// boot time and is always ready; write it only while the block is idle.
// Sequence: a load or an unused opcode is taken in the idle step. A compare is
// accepted, adds the boot time, takes one to three wrap steps, scans the on table
// from the kept on pointer, makes a decision step, scans the off table when no
// on-time matched, and posts the result. The scan visits one slot per cycle because
// each table memory has a single registered read port. The input stalls while a
// compare runs.
// Reset clears the valid marks, both scan pointers, the boot time and the output;
// table contents stay undefined and are never used before they are written. A
// finished result waits in the output register while the receiver stalls; the next
// item is still accepted, and only a second compare waits for that register.
module time_of_day_switch_matcher #(
  parameter int unsigned SLOTS = tdsm_pkg::SLOTS_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write channel.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tdsm_pkg::MINUTE_W-1:0] cfg_boot_minutes_i,
  // Input channel.
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [tdsm_pkg::OPCODE_W-1:0] opcode_i,
  input  logic [tdsm_pkg::SLOT_W-1:0]   entry_slot_i,
  input  logic [tdsm_pkg::MINUTE_W-1:0] entry_minute_i,
  input  logic                          entry_enable_i,
  input  logic [tdsm_pkg::MINUTE_W-1:0] elapsed_minutes_i,
  // Output channel.
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [tdsm_pkg::CMD_W-1:0]    command_o,
  output logic [tdsm_pkg::MINUTE_W-1:0] current_minute_o
);

  import tdsm_pkg::*;

  localparam int unsigned PtrW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [PtrW-1:0]  LastPtr = PtrW'(SLOTS - 1);
  localparam logic [CMD_W-1:0] OffBase = CMD_W'(SLOTS + 1);

  // Sequencer state.
  step_e step_q, step_d;
  ctrl_t cw;
  logic  jump;

  // Datapath registers.
  logic [PtrW-1:0]     on_ptr_q, on_ptr_d;
  logic [PtrW-1:0]     off_ptr_q, off_ptr_d;
  logic [SLOTS-1:0]    on_valid_q;
  logic [SLOTS-1:0]    off_valid_q;
  logic [SUM_W-1:0]    cur_q, cur_d;
  logic                hit_q, hit_d;
  logic [CMD_W-1:0]    cmd_q, cmd_d;
  logic [MINUTE_W-1:0] boot_q;
  logic                out_valid_q, out_valid_d;
  logic [CMD_W-1:0]    out_cmd_q, out_cmd_d;
  logic [MINUTE_W-1:0] out_min_q, out_min_d;

  logic                in_accept;
  logic                cmp_accept;
  logic                slot_ok;
  logic [PtrW-1:0]     wr_addr;
  logic                on_we;
  logic                off_we;
  logic [MINUTE_W-1:0] on_rdata;
  logic [MINUTE_W-1:0] off_rdata;
  logic                on_hit;
  logic                off_hit;
  logic                out_free;

  // ---------------------------------------------------------------------------
  // Handshakes and table writes. Loads are written straight from the ports in
  // the cycle the transaction is accepted.
  // ---------------------------------------------------------------------------
  assign cw          = tdsm_ucode(step_q);
  assign in_stall_o  = ~cw.ready;
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign cmp_accept  = in_accept & (opcode_i == OP_COMPARE);
  assign cfg_ready_o = 1'b1;

  // Loads to a slot beyond the table are dropped.
  assign slot_ok = {3'b000, entry_slot_i} < 7'(SLOTS);
  assign wr_addr = PtrW'(entry_slot_i);
  assign on_we   = in_accept & (opcode_i == OP_LOAD_ON) & slot_ok;
  assign off_we  = in_accept & (opcode_i == OP_LOAD_OFF) & slot_ok;

  // The read address follows the next pointer value, so the registered read
  // data always holds the entry that the current pointer selects.
  tdsm_ram #(
    .Width (MINUTE_W),
    .Depth (SLOTS)
  ) u_on_ram (
    .clk_i   (clk_i),
    .we_i    (on_we),
    .waddr_i (wr_addr),
    .wdata_i (entry_minute_i),
    .raddr_i (on_ptr_d),
    .rdata_o (on_rdata)
  );

  tdsm_ram #(
    .Width (MINUTE_W),
    .Depth (SLOTS)
  ) u_off_ram (
    .clk_i   (clk_i),
    .we_i    (off_we),
    .waddr_i (wr_addr),
    .wdata_i (entry_minute_i),
    .raddr_i (off_ptr_d),
    .rdata_o (off_rdata)
  );

  // An invalid slot never matches, so stale table contents never decide a result.
  assign on_hit   = on_valid_q[on_ptr_q] & ({1'b0, on_rdata} == cur_q);
  assign off_hit  = off_valid_q[off_ptr_q] & ({1'b0, off_rdata} == cur_q);
  assign out_free = ~out_valid_q | ~out_stall_i;

  // ---------------------------------------------------------------------------
  // Next step: evaluate the control word's jump condition.
  // ---------------------------------------------------------------------------
  always_comb begin
    unique case (cw.cond)
      COND_NEVER:      jump = 1'b0;
      COND_NO_COMPARE: jump = ~cmp_accept;
      COND_WRAP:       jump = (cur_q >= DAY_MINUTES);
      COND_ON_MORE:    jump = ~on_hit & (on_ptr_q != LastPtr);
      COND_OFF_MORE:   jump = ~off_hit & (off_ptr_q != LastPtr);
      COND_HIT:        jump = hit_q;
      COND_OUT_BUSY:   jump = ~out_free;
      default:         jump = 1'b0;
    endcase
    step_d = jump ? cw.target_step : cw.next_step;
  end

  // ---------------------------------------------------------------------------
  // Datapath operation selected by the control word.
  // ---------------------------------------------------------------------------
  always_comb begin
    on_ptr_d    = on_ptr_q;
    off_ptr_d   = off_ptr_q;
    cur_d       = cur_q;
    hit_d       = hit_q;
    cmd_d       = cmd_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_cmd_d   = out_cmd_q;
    out_min_d   = out_min_q;
    unique case (cw.act)
      ACT_NONE: begin
      end
      ACT_CAPTURE: begin
        if (cmp_accept) begin
          // Elapsed values outside one day count as zero.
          cur_d = ({1'b0, elapsed_minutes_i} >= DAY_MINUTES) ? '0
                                                             : {1'b0, elapsed_minutes_i};
          hit_d = 1'b0;
          cmd_d = '0;
        end
      end
      ACT_ADD: begin
        cur_d = cur_q + {1'b0, boot_q};
      end
      ACT_WRAP: begin
        if (cur_q >= DAY_MINUTES) begin
          cur_d = cur_q - DAY_MINUTES;
        end
      end
      ACT_SCAN_ON: begin
        // A matched pointer stays put; an exhausted scan returns to slot zero.
        if (on_hit) begin
          hit_d = 1'b1;
          cmd_d = CMD_W'(on_ptr_q) + CMD_W'(1);
        end else if (on_ptr_q == LastPtr) begin
          on_ptr_d = '0;
        end else begin
          on_ptr_d = on_ptr_q + 1'b1;
        end
      end
      ACT_SCAN_OFF: begin
        if (off_hit) begin
          hit_d = 1'b1;
          cmd_d = CMD_W'(off_ptr_q) + OffBase;
        end else if (off_ptr_q == LastPtr) begin
          off_ptr_d = '0;
        end else begin
          off_ptr_d = off_ptr_q + 1'b1;
        end
      end
      ACT_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_cmd_d   = cmd_q;
          out_min_d   = cur_q[MINUTE_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_IDLE;
      on_ptr_q    <= '0;
      off_ptr_q   <= '0;
      on_valid_q  <= '0;
      off_valid_q <= '0;
      hit_q       <= 1'b0;
      boot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      on_ptr_q    <= on_ptr_d;
      off_ptr_q   <= off_ptr_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
      if (on_we) begin
        on_valid_q[wr_addr] <= entry_enable_i;
      end
      if (off_we) begin
        off_valid_q[wr_addr] <= entry_enable_i;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        boot_q <= cfg_boot_minutes_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    cmd_q     <= cmd_d;
    out_cmd_q <= out_cmd_d;
    out_min_q <= out_min_d;
  end

  assign out_valid_o      = out_valid_q;
  assign command_o        = out_cmd_q;
  assign current_minute_o = out_min_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_min_in_day: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, current_minute_o} < DAY_MINUTES))
    else $error("posted minute is outside one day");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (on_ptr_q <= LastPtr) && (off_ptr_q <= LastPtr))
    else $error("scan pointer beyond the table");

  a_emit_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == STEP_OUT) && out_free |=> out_valid_o && (step_q == STEP_IDLE))
    else $error("finished compare did not reach the output register");

  a_scan_cur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == STEP_ON) || (step_q == STEP_OFF) |-> (cur_q < DAY_MINUTES))
    else $error("scan started before the minute was wrapped");

endmodule

// ===== tb/tb_time_of_day_switch_matcher.sv =====
// Self-checking testbench for the time-of-day switch matcher.
`timescale 1ns / 1ps

// The bench drives load, compare and unused-opcode transactions into the matcher and
// checks every result transaction against a predictor that keeps its own copy of the
// on and off tables, their valid marks, both scan pointers and the boot time.
// A short directed sequence covers the table extremes, pointer stickiness, the zeroing
// of out-of-day elapsed values and an over-range boot time. Random phases then run
// with different boot times and with sender idling and receiver stalls of varying
// density. Inputs change on the falling clock edge; outputs are sampled on the rising
// edge.
module tb_time_of_day_switch_matcher;
  import tdsm_pkg::*;

  localparam int unsigned SLOTS        = SLOTS_DEFAULT;
  localparam int unsigned DAY          = 24 * 60;
  // Drain time: longer than the longest compare, with margin.
  localparam int unsigned DRAIN_CYCLES = 2 * SLOTS + 16;
  localparam int unsigned PHASE_ITEMS  = 375;
  localparam int          ON_SIDE      = 0;
  localparam int          OFF_SIDE     = 1;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [MINUTE_W-1:0] minute;
  } switch_result_t;

  // Predicts the switch command for each accepted transaction and holds the
  // results that are still due from the block.
  class switch_scoreboard;
    logic [MINUTE_W-1:0] boot;
    logic [MINUTE_W-1:0] minute_tbl[2][SLOTS];
    bit                  valid_tbl[2][SLOTS];
    logic [4:0]          scan_ptr[2];
    switch_result_t      pending_q[$];
    int                  errors = 0;

    function void clear();
      boot = '0;
      scan_ptr[ON_SIDE] = '0;
      scan_ptr[OFF_SIDE] = '0;
      foreach (valid_tbl[s, i]) valid_tbl[s][i] = 1'b0;
    endfunction

    // Walks one table upward from its kept pointer. A hit leaves the pointer on the
    // matching slot; a miss sends the pointer back to slot zero.
    function bit scan(int side, logic [MINUTE_W-1:0] cur);
      while (scan_ptr[side] < SLOTS) begin
        if (valid_tbl[side][scan_ptr[side]] && minute_tbl[side][scan_ptr[side]] == cur)
          return 1'b1;
        scan_ptr[side]++;
      end
      scan_ptr[side] = '0;
      return 1'b0;
    endfunction

    function void note_item(opcode_e op, logic [SLOT_W-1:0] slot,
                            logic [MINUTE_W-1:0] minute, logic en,
                            logic [MINUTE_W-1:0] elapsed);
      int             side;
      int             day_min;
      switch_result_t res;
      case (op)
        OP_LOAD_ON, OP_LOAD_OFF: begin
          side = (op == OP_LOAD_ON) ? ON_SIDE : OFF_SIDE;
          if (slot < SLOTS) begin
            minute_tbl[side][slot] = minute;
            valid_tbl[side][slot] = en;
          end
        end
        OP_COMPARE: begin
          day_min = (elapsed >= DAY) ? 0 : int'(elapsed);
          day_min = (int'(boot) + day_min) % DAY;
          res.minute = MINUTE_W'(day_min);
          if (scan(ON_SIDE, res.minute))
            res.command = CMD_W'(scan_ptr[ON_SIDE] + 1);
          else if (scan(OFF_SIDE, res.minute))
            res.command = CMD_W'(scan_ptr[OFF_SIDE] + 1 + SLOTS);
          else
            res.command = '0;
          pending_q.push_back(res);
        end
        default: begin
        end
      endcase
    endfunction

    function void check_result(logic [CMD_W-1:0] command, logic [MINUTE_W-1:0] minute);
      switch_result_t want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result, command %0d minute %0d", $time, command, minute);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (want.command !== command) begin
        $display("%0t: command mismatch, expected %0d actual %0d", $time, want.command,
                 command);
        errors++;
      end
      if (want.minute !== minute) begin
        $display("%0t: current minute mismatch, expected %0d actual %0d", $time,
                 want.minute, minute);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i              = 1'b0;
  logic                rst_ni             = 1'b0;
  logic                cfg_valid_i        = 1'b0;
  logic                cfg_ready_o;
  logic [MINUTE_W-1:0] cfg_boot_minutes_i = '0;
  logic                in_valid_i         = 1'b0;
  logic                in_stall_o;
  logic [OPCODE_W-1:0] opcode_i           = OP_NONE;
  logic [SLOT_W-1:0]   entry_slot_i       = '0;
  logic [MINUTE_W-1:0] entry_minute_i     = '0;
  logic                entry_enable_i     = 1'b0;
  logic [MINUTE_W-1:0] elapsed_minutes_i  = '0;
  logic                out_valid_o;
  logic                out_stall_i        = 1'b0;
  logic [CMD_W-1:0]    command_o;
  logic [MINUTE_W-1:0] current_minute_o;

  switch_scoreboard    switch_check;
  int                  send_idle_pct = 0;
  int                  stall_pct     = 0;
  int                  boot_now      = 0;
  logic [MINUTE_W-1:0] minute_pool[8];

  time_of_day_switch_matcher #(.SLOTS(SLOTS)) uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_boot_minutes_i (cfg_boot_minutes_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .opcode_i           (opcode_i),
    .entry_slot_i       (entry_slot_i),
    .entry_minute_i     (entry_minute_i),
    .entry_enable_i     (entry_enable_i),
    .elapsed_minutes_i  (elapsed_minutes_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .command_o          (command_o),
    .current_minute_o   (current_minute_o)
  );

  always #2 clk_i = ~clk_i;

  // The receiver decides its stall for each cycle on the falling edge.
  always @(negedge clk_i) begin
    out_stall_i = ($urandom_range(99) < stall_pct);
  end

  // A result transaction completes on a rising edge with valid high and no stall.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      switch_check.check_result(command_o, current_minute_o);
  end

  // Presents one input transaction, with a random idle gap in front of it, and holds
  // it until the block takes it. Entered and left just after a falling edge.
  task automatic send_item(input opcode_e op, input logic [SLOT_W-1:0] slot,
                           input logic [MINUTE_W-1:0] minute, input logic en,
                           input logic [MINUTE_W-1:0] elapsed);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    opcode_i = op;
    entry_slot_i = slot;
    entry_minute_i = minute;
    entry_enable_i = en;
    elapsed_minutes_i = elapsed;
    do @(posedge clk_i); while (in_stall_o);
    switch_check.note_item(op, slot, minute, en, elapsed);
    @(negedge clk_i);
  endtask

  // Compare with don't-care load fields randomized.
  task automatic send_compare(input logic [MINUTE_W-1:0] elapsed);
    send_item(OP_COMPARE, SLOT_W'($urandom), MINUTE_W'($urandom), 1'($urandom), elapsed);
  endtask

  task automatic send_load(input opcode_e op, input int slot, input int minute,
                           input logic en);
    send_item(op, SLOT_W'(slot), MINUTE_W'(minute), en, MINUTE_W'($urandom));
  endtask

  // Stops sending and waits until every predicted result has been seen, then lets
  // a trailing load or ignored transaction finish inside the block.
  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (switch_check.pending_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_boot(input logic [MINUTE_W-1:0] value);
    cfg_valid_i = 1'b1;
    cfg_boot_minutes_i = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    switch_check.boot = value;
    boot_now = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Random traffic. Loads draw minutes mostly from a small pool so that slots share
  // times across and within tables, and most compares are aimed at a pool minute so
  // that the scans actually hit and the kept pointers come into play.
  task automatic random_item();
    int                  pick;
    int                  minute;
    int                  target;
    logic [MINUTE_W-1:0] elapsed;
    pick = $urandom_range(99);
    if (pick < 30) begin
      pick = $urandom_range(99);
      if (pick < 85)
        minute = minute_pool[$urandom_range(7)];
      else if (pick < 95)
        minute = $urandom_range(2047);
      else
        minute = $urandom_range(1) ? DAY - 1 : 0;
      send_load($urandom_range(1) ? OP_LOAD_ON : OP_LOAD_OFF, $urandom_range(SLOTS - 1),
                minute, ($urandom_range(9) < 8));
    end else if (pick < 95) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        target = minute_pool[$urandom_range(7)];
        elapsed = MINUTE_W'((target + DAY - (boot_now % DAY)) % DAY);
      end else if (pick < 90) begin
        elapsed = MINUTE_W'($urandom_range(2047));
      end else begin
        elapsed = MINUTE_W'($urandom_range(2047, DAY));
      end
      send_compare(elapsed);
    end else begin
      send_item(OP_NONE, SLOT_W'($urandom), MINUTE_W'($urandom), 1'($urandom),
                MINUTE_W'($urandom));
    end
  endtask

  initial begin
    int phase;
    switch_check = new;
    switch_check.clear();
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Write every slot of both tables once, marked invalid, so that no scan ever
    // touches a table word that was never written.
    for (int s = 0; s < SLOTS; s++) begin
      send_load(OP_LOAD_ON, s, $urandom_range(DAY - 1), 1'b0);
      send_load(OP_LOAD_OFF, s, $urandom_range(DAY - 1), 1'b0);
    end

    // Directed sequence with the boot time still at its reset value of zero.
    send_compare(11'd0);                          // nothing valid: no command
    send_load(OP_LOAD_ON, 0, 0, 1'b1);
    send_load(OP_LOAD_ON, SLOTS - 1, DAY - 1, 1'b1);
    send_load(OP_LOAD_OFF, SLOTS - 1, 0, 1'b1);   // same minute as on slot 0
    send_load(OP_LOAD_OFF, 0, DAY - 1, 1'b1);
    send_load(OP_LOAD_ON, 7, 2047, 1'b1);         // stored past the day: never hits
    send_load(OP_LOAD_OFF, 8, DAY, 1'b1);
    send_compare(11'd0);                          // on slot 0 hits first
    send_compare(11'(DAY));                       // elapsed past the day counts as 0
    send_compare(11'd2047);
    send_compare(11'(DAY - 1));                   // on pointer moves to the last slot
    send_compare(11'd0);                          // on scan from last slot misses
    send_compare(11'(DAY - 1));
    send_load(OP_LOAD_ON, SLOTS - 1, DAY - 1, 1'b0);
    send_compare(11'(DAY - 1));                   // off scan starts at the kept pointer
    send_compare(11'(DAY - 1));                   // off scan now from slot 0
    send_item(OP_NONE, '1, '1, 1'b1, '1);         // unused opcode is ignored
    send_compare(11'd1000);

    // Let every result come back before touching the boot time.
    wait_drained();
    write_boot(11'd2047);                         // boot beyond the day still wraps
    send_compare(11'(DAY - 1));
    send_compare(11'd2047);
    send_compare(11'd0);

    for (phase = 0; phase < 4; phase++) begin
      wait_drained();
      case (phase)
        0: begin
          write_boot(11'(DAY - 1));
          send_idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          write_boot(11'($urandom_range(DAY - 1)));
          send_idle_pct = 67;
          stall_pct = 0;
        end
        2: begin
          write_boot(11'd0);
          send_idle_pct = 0;
          stall_pct = 67;
        end
        default: begin
          write_boot(11'($urandom_range(2047)));
          send_idle_pct = 28;
          stall_pct = 28;
        end
      endcase
      foreach (minute_pool[i]) minute_pool[i] = MINUTE_W'($urandom_range(DAY - 1));
      repeat (PHASE_ITEMS) random_item();
    end

    wait_drained();
    if (switch_check.errors == 0 && switch_check.pending_q.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Guards against a hung handshake.
  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/tdsm_pkg.sv
hdl/tdsm_ram.sv
hdl/time_of_day_switch_matcher.sv
tb/tb_time_of_day_switch_matcher.sv
